/* rtl/core/fsfp_pkg.sv */
// shared types and character codes for the format spec flag parser
`timescale 1ns / 1ps

package fsfp_pkg;

   // default accumulator width for field width and precision
   localparam int NUMBER_BITS_DEF = 16;

   // character codes
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_H     = 8'h68;
   localparam logic [7:0] CHAR_L     = 8'h6C;
   localparam logic [7:0] CHAR_J     = 8'h6A;
   localparam logic [7:0] CHAR_Z     = 8'h7A;

   // attribute flag bit positions
   localparam int FLAG_ALT   = 0;
   localparam int FLAG_ZERO  = 1;
   localparam int FLAG_PLUS  = 2;
   localparam int FLAG_LEFT  = 3;
   localparam int FLAG_SPACE = 4;

   // length modifier levels
   localparam logic [1:0] LEVEL_NONE   = 2'd0;
   localparam logic [1:0] LEVEL_SINGLE = 2'd1;
   localparam logic [1:0] LEVEL_DOUBLE = 2'd2;

   // input transaction
   typedef struct packed {
      logic [7:0] char_in;
      logic       spec_start;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [7:0]  conv_char;
      logic [4:0]  attr_flags;
      logic [15:0] min_width;
      logic [15:0] prec_value;
      logic        has_precision;
      logic [1:0]  short_level;
      logic [1:0]  long_level;
      logic        intmax_mod;
      logic        sizet_mod;
   } rsp_type;

endpackage

/* rtl/core/fsfp_digit_acc.sv */
// saturating decimal accumulate: acc * 10 + digit, clamped to all ones
`timescale 1ns / 1ps

module fsfp_digit_acc
   import fsfp_pkg::*;
#(
   parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
   input  logic [NUMBER_BITS-1:0] acc_val,
   input  logic [7:0]             digit_char,
   output logic [NUMBER_BITS-1:0] next_val
);

   localparam int SUM_BITS = NUMBER_BITS + 4;

   logic [3:0]          digit_off;
   logic [SUM_BITS-1:0] acc_ext;
   logic [SUM_BITS-1:0] sum_val;

   // times ten as two shifts and an add, then the digit
   always_comb begin
      digit_off = 4'(digit_char - CHAR_ZERO);
      acc_ext   = {4'b0000, acc_val};
      sum_val   = (acc_ext << 3) + (acc_ext << 1) + SUM_BITS'(digit_off);
   end

   // clamp on any overflow into the top bits
   assign next_val = (sum_val[SUM_BITS-1:NUMBER_BITS] != 4'b0000) ?
                     {NUMBER_BITS{1'b1}} : sum_val[NUMBER_BITS-1:0];

endmodule

/* rtl/core/format_spec_flag_parser.sv */
// top level of the format spec flag parser
`timescale 1ns / 1ps

// Streaming parser for the text after a percent sign in a printf style
// format. One character is taken per clock cycle, the first of each
// specification marked by spec_start. Flags, field width, precision and
// length modifiers are collected in state registers; the first character
// that fits none of them is returned with every parsed field in the cycle
// after it was taken, from a single result register. The input stalls only
// while that register holds a result that the output side is stalling, so
// the sustained rate is one character per cycle. Width and precision
// accumulate in NUMBER_BITS wide registers, saturate at all ones and are
// presented as 16 bits.

module format_spec_flag_parser
   import fsfp_pkg::*;
#(
   parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ATTR,
      PH_WIDTH,
      PH_PREC,
      PH_LEN
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [4:0]             attr_ff, attr_in;
   logic [NUMBER_BITS-1:0] width_ff, width_in;
   logic [NUMBER_BITS-1:0] prec_ff, prec_in;
   logic                   prec_seen_ff, prec_seen_in;
   logic [1:0]             short_ff, short_in;
   logic [1:0]             long_ff, long_in;
   logic                   j_seen_ff, j_seen_in;
   logic                   z_seen_ff, z_seen_in;
   logic                   open_h_ff, open_h_in;
   logic                   open_l_ff, open_l_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   // working view of the state, cleared when a new spec starts
   phase_type              cur_phase;
   logic [4:0]             cur_attr;
   logic [NUMBER_BITS-1:0] cur_width;
   logic [NUMBER_BITS-1:0] cur_prec;
   logic                   cur_prec_seen;
   logic [1:0]             cur_short;
   logic [1:0]             cur_long;
   logic                   cur_j;
   logic                   cur_z;
   logic                   cur_open_h;
   logic                   cur_open_l;

   logic                   accept;
   logic [7:0]             ch;
   logic                   is_digit;
   logic                   is_nonzero;
   logic                   is_len;
   logic                   is_attr;
   logic [4:0]             attr_mask;
   logic                   taken;
   logic [4:0]             flags_out;
   logic [NUMBER_BITS-1:0] width_next;
   logic [NUMBER_BITS-1:0] prec_next;

   // transaction handshake
   assign accept    = req_valid & ~req_stall;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign ch        = req_data.char_in;

   // character classes
   always_comb begin
      is_digit   = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
      is_nonzero = (ch >= CHAR_ONE) && (ch <= CHAR_NINE);
      is_len     = (ch == CHAR_H) || (ch == CHAR_L) || (ch == CHAR_J) || (ch == CHAR_Z);
      attr_mask  = '0;
      unique case (ch)
         CHAR_HASH:  attr_mask[FLAG_ALT]   = 1'b1;
         CHAR_ZERO:  attr_mask[FLAG_ZERO]  = 1'b1;
         CHAR_PLUS:  attr_mask[FLAG_PLUS]  = 1'b1;
         CHAR_MINUS: attr_mask[FLAG_LEFT]  = 1'b1;
         CHAR_SPACE: attr_mask[FLAG_SPACE] = 1'b1;
         default:    attr_mask = '0;
      endcase
      is_attr = (attr_mask != '0);
   end

   // state seen by this character
   always_comb begin
      if (req_data.spec_start) begin
         cur_phase     = PH_ATTR;
         cur_attr      = '0;
         cur_width     = '0;
         cur_prec      = '0;
         cur_prec_seen = 1'b0;
         cur_short     = LEVEL_NONE;
         cur_long      = LEVEL_NONE;
         cur_j         = 1'b0;
         cur_z         = 1'b0;
         cur_open_h    = 1'b0;
         cur_open_l    = 1'b0;
      end else begin
         cur_phase     = phase_ff;
         cur_attr      = attr_ff;
         cur_width     = width_ff;
         cur_prec      = prec_ff;
         cur_prec_seen = prec_seen_ff;
         cur_short     = short_ff;
         cur_long      = long_ff;
         cur_j         = j_seen_ff;
         cur_z         = z_seen_ff;
         cur_open_h    = open_h_ff;
         cur_open_l    = open_l_ff;
      end
   end

   // decimal accumulators for width and precision
   fsfp_digit_acc #(
      .NUMBER_BITS(NUMBER_BITS)
   ) u_width_acc (
      .acc_val    (cur_width),
      .digit_char (ch),
      .next_val   (width_next)
   );

   fsfp_digit_acc #(
      .NUMBER_BITS(NUMBER_BITS)
   ) u_prec_acc (
      .acc_val    (cur_prec),
      .digit_char (ch),
      .next_val   (prec_next)
   );

   // flag overrides applied at emit
   always_comb begin
      flags_out = cur_attr;
      if (cur_attr[FLAG_LEFT] || cur_prec_seen) begin
         flags_out[FLAG_ZERO] = 1'b0;
      end
      if (cur_attr[FLAG_PLUS]) begin
         flags_out[FLAG_SPACE] = 1'b0;
      end
   end

   // per character phase step
   always_comb begin
      phase_in     = phase_ff;
      attr_in      = attr_ff;
      width_in     = width_ff;
      prec_in      = prec_ff;
      prec_seen_in = prec_seen_ff;
      short_in     = short_ff;
      long_in      = long_ff;
      j_seen_in    = j_seen_ff;
      z_seen_in    = z_seen_ff;
      open_h_in    = open_h_ff;
      open_l_in    = open_l_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      taken        = 1'b0;

      if (accept && (cur_phase != PH_IDLE)) begin
         phase_in     = cur_phase;
         attr_in      = cur_attr;
         width_in     = cur_width;
         prec_in      = cur_prec;
         prec_seen_in = cur_prec_seen;
         short_in     = cur_short;
         long_in      = cur_long;
         j_seen_in    = cur_j;
         z_seen_in    = cur_z;
         open_h_in    = cur_open_h;
         open_l_in    = cur_open_l;

         // flags, width and precision phases
         unique case (cur_phase)
            PH_ATTR: begin
               if (is_attr) begin
                  attr_in = cur_attr | attr_mask;
                  taken   = 1'b1;
               end else if (is_nonzero) begin
                  width_in = width_next;
                  phase_in = PH_WIDTH;
                  taken    = 1'b1;
               end else if (ch == CHAR_DOT) begin
                  prec_seen_in = 1'b1;
                  prec_in      = '0;
                  phase_in     = PH_PREC;
                  taken        = 1'b1;
               end
            end
            PH_WIDTH: begin
               if (is_digit) begin
                  width_in = width_next;
                  taken    = 1'b1;
               end else if (ch == CHAR_DOT) begin
                  prec_seen_in = 1'b1;
                  prec_in      = '0;
                  phase_in     = PH_PREC;
                  taken        = 1'b1;
               end
            end
            PH_PREC: begin
               if (is_digit) begin
                  prec_in = prec_next;
                  taken   = 1'b1;
               end
            end
            default: begin
               taken = 1'b0;
            end
         endcase

         // length modifiers, else emit the conversion character
         if (!taken) begin
            if (is_len) begin
               open_h_in = 1'b0;
               open_l_in = 1'b0;
               phase_in  = PH_LEN;
               if (ch == CHAR_H) begin
                  if (cur_open_h) begin
                     short_in = LEVEL_DOUBLE;
                  end else begin
                     short_in  = LEVEL_SINGLE;
                     open_h_in = 1'b1;
                  end
               end else if (ch == CHAR_L) begin
                  if (cur_open_l) begin
                     long_in = LEVEL_DOUBLE;
                  end else begin
                     long_in   = LEVEL_SINGLE;
                     open_l_in = 1'b1;
                  end
               end else if (ch == CHAR_J) begin
                  j_seen_in = 1'b1;
               end else begin
                  z_seen_in = 1'b1;
               end
            end else begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.conv_char     = ch;
               rsp_data_in.attr_flags    = flags_out;
               rsp_data_in.min_width     = 16'(cur_width);
               rsp_data_in.prec_value    = 16'(cur_prec);
               rsp_data_in.has_precision = cur_prec_seen;
               rsp_data_in.short_level   = cur_short;
               rsp_data_in.long_level    = cur_long;
               rsp_data_in.intmax_mod    = cur_j;
               rsp_data_in.sizet_mod     = cur_z;
               phase_in     = PH_IDLE;
               attr_in      = '0;
               width_in     = '0;
               prec_in      = '0;
               prec_seen_in = 1'b0;
               short_in     = LEVEL_NONE;
               long_in      = LEVEL_NONE;
               j_seen_in    = 1'b0;
               z_seen_in    = 1'b0;
               open_h_in    = 1'b0;
               open_l_in    = 1'b0;
            end
         end
      end
   end

   // state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         attr_ff      <= '0;
         width_ff     <= '0;
         prec_ff      <= '0;
         prec_seen_ff <= 1'b0;
         short_ff     <= LEVEL_NONE;
         long_ff      <= LEVEL_NONE;
         j_seen_ff    <= 1'b0;
         z_seen_ff    <= 1'b0;
         open_h_ff    <= 1'b0;
         open_l_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         attr_ff      <= attr_in;
         width_ff     <= width_in;
         prec_ff      <= prec_in;
         prec_seen_ff <= prec_seen_in;
         short_ff     <= short_in;
         long_ff      <= long_in;
         j_seen_ff    <= j_seen_in;
         z_seen_ff    <= z_seen_in;
         open_h_ff    <= open_h_in;
         open_l_ff    <= open_l_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule
